// ----- design/ncdb_pkg.sv -----
`timescale 1ns / 1ps

package ncdb_pkg;

  localparam int FEAT_W    = 16;
  localparam int CENT_W    = 48;
  localparam int DSQ_W     = 34;
  localparam int WCSS_W    = 63;
  localparam int DB_W      = 32;
  localparam int SCAT_W    = 40;
  localparam int AVG_W     = 48;
  localparam int RAD_W     = 50;
  localparam int ROOT_W    = 25;
  localparam int NUM_W     = 64;
  localparam int DEN_W     = 25;
  localparam int FLOOR_W   = 16;
  localparam int CNT_CFG_W = 5;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_POINT  = 2'd1,
    MODE_FINISH = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  localparam logic [2:0] ST_LOADED   = 3'd0;
  localparam logic [2:0] ST_ASSIGNED = 3'd1;
  localparam logic [2:0] ST_METRICS  = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_BAD_SLOT = 3'd4;

  localparam logic [0:0] REG_CLUSTER_COUNT    = 1'b0;
  localparam logic [0:0] REG_SEPARATION_FLOOR = 1'b1;

  typedef struct packed {
    mode_t             mode;
    logic [3:0]        cluster_index;
    logic [FEAT_W-1:0] feature_c;
    logic [FEAT_W-1:0] feature_b;
    logic [FEAT_W-1:0] feature_a;
  } item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [3:0]        label;
    logic [DSQ_W-1:0]  distance_sq;
    logic [WCSS_W-1:0] wcss;
    logic [DB_W-1:0]   davies_bouldin;
  } res_t;

  typedef struct packed {
    logic [CNT_CFG_W-1:0] cluster_count;
    logic [FLOOR_W-1:0]   separation_floor;
  } cfg_t;

endpackage

// ----- design/ncdb_front.sv -----
`timescale 1ns / 1ps

module ncdb_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  ncdb_pkg::item_t in_item,
  output logic          item_valid,
  output ncdb_pkg::item_t item,
  input  logic          item_pop
);

  ncdb_pkg::item_t q_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  logic            push;
  logic            pop;

  assign in_ready   = (count_r != 2'd2);
  assign push       = in_valid && in_ready && (in_item.mode != ncdb_pkg::MODE_NONE);
  assign item_valid = (count_r != 2'd0);
  assign item       = q_r[rd_ptr_r];
  assign pop        = item_pop && item_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- design/ncdb_sqrt.sv -----
`timescale 1ns / 1ps

module ncdb_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [ncdb_pkg::RAD_W-1:0]  radicand,
  output logic                        done,
  output logic [ncdb_pkg::ROOT_W-1:0] root
);

  localparam int RW = ncdb_pkg::ROOT_W;

  logic [ncdb_pkg::RAD_W-1:0] n_r;
  logic [RW+2:0]              rem_r;
  logic [RW-1:0]              root_r;
  logic [4:0]                 cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [RW+2:0]              rem_sh;
  logic [RW+2:0]              trial;
  logic                       fits;

  assign rem_sh = {rem_r[RW:0], n_r[ncdb_pkg::RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);
  assign done   = done_r;
  assign root   = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        n_r    <= radicand;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= 5'(RW - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        n_r    <= {n_r[ncdb_pkg::RAD_W-3:0], 2'b00};
        rem_r  <= fits ? (rem_sh - trial) : rem_sh;
        root_r <= {root_r[RW-2:0], fits};
        cnt_r  <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/ncdb_div.sv -----
`timescale 1ns / 1ps

module ncdb_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [ncdb_pkg::NUM_W-1:0] num,
  input  logic [ncdb_pkg::DEN_W-1:0] den,
  output logic                       done,
  output logic [ncdb_pkg::NUM_W-1:0] quot
);

  localparam int NW = ncdb_pkg::NUM_W;
  localparam int DW = ncdb_pkg::DEN_W;

  logic [NW-1:0] n_r;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [5:0]    cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;
  logic          fits;

  assign rem_sh  = {rem_r, n_r[NW-1]};
  assign fits    = (rem_sh >= {1'b0, den_r});
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign done    = done_r;
  assign quot    = n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        n_r    <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= 6'(NW - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
        n_r   <= {n_r[NW-2:0], fits};
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/ncdb_back.sv -----
`timescale 1ns / 1ps

module ncdb_back #(
  parameter int MAX_CLUSTERS = 16,
  parameter int DIMS         = 3,
  parameter int MAX_POINTS   = 1048576
) (
  input  logic            clk,
  input  logic            rst_n,
  input  ncdb_pkg::cfg_t  cfg,
  input  logic            item_valid,
  input  ncdb_pkg::item_t item,
  output logic            item_pop,
  output logic            res_valid,
  output ncdb_pkg::res_t  res,
  input  logic            res_take
);

  localparam int AW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KW = $clog2(MAX_CLUSTERS + 1);
  localparam int PW = $clog2(MAX_POINTS + 1);
  localparam int FW = ncdb_pkg::FEAT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_PT_WAIT, S_PT_ACC, S_PT_CMP, S_PT_FIN, S_PT_ROOT,
    S_AVG_GO, S_AVG_WAIT, S_PI_WAIT, S_PI_LOAD, S_PJ_NEXT, S_PJ_WAIT,
    S_PJ_ACC, S_PJ_ROOT, S_PJ_DIV, S_DB_DIV
  } state_t;

  state_t                         state_r;
  logic [ncdb_pkg::CENT_W-1:0]    cent_mem [MAX_CLUSTERS];
  logic [ncdb_pkg::CENT_W-1:0]    cent_q_r;
  logic [AW-1:0]                  rd_addr_r;
  logic [ncdb_pkg::CENT_W-1:0]    p_r;
  logic [ncdb_pkg::CENT_W-1:0]    ci_r;
  logic [1:0]                     dim_r;
  logic [ncdb_pkg::DSQ_W-1:0]     acc_r;
  logic [ncdb_pkg::DSQ_W-1:0]     best_r;
  logic [AW-1:0]                  bestj_r;
  logic [KW-1:0]                  i_r;
  logic [KW-1:0]                  j_r;
  logic [ncdb_pkg::NUM_W-1:0]     worst_r;
  logic [ncdb_pkg::NUM_W-1:0]     total_r;
  logic [ncdb_pkg::AVG_W-1:0]     avg_r  [MAX_CLUSTERS];
  logic [ncdb_pkg::SCAT_W-1:0]    scat_r [MAX_CLUSTERS];
  logic [PW-1:0]                  cnt_r  [MAX_CLUSTERS];
  logic [ncdb_pkg::WCSS_W-1:0]    wcss_r;
  logic [PW-1:0]                  seen_r;
  logic                           res_valid_r;
  ncdb_pkg::res_t                 res_r;
  logic                           sq_go_r;
  logic [ncdb_pkg::RAD_W-1:0]     sq_rad_r;
  logic                           dv_go_r;
  logic [ncdb_pkg::NUM_W-1:0]     dv_num_r;
  logic [ncdb_pkg::DEN_W-1:0]     dv_den_r;

  logic                           sq_done;
  logic [ncdb_pkg::ROOT_W-1:0]    sq_root;
  logic                           dv_done;
  logic [ncdb_pkg::NUM_W-1:0]     dv_quot;

  logic [KW-1:0]                  k;
  logic                           slot_ok;
  logic                           mem_we;
  logic [FW-1:0]                  opa;
  logic [FW-1:0]                  opb;
  logic [FW:0]                    diff;
  logic [FW:0]                    mag;
  logic [2*FW-1:0]                sq;
  logic [ncdb_pkg::DSQ_W-1:0]     acc_nxt;
  logic                           dim_last;
  logic                           pt_better;
  logic [ncdb_pkg::DSQ_W-1:0]     best_nxt;
  logic [AW-1:0]                  bestj_nxt;
  logic [ncdb_pkg::WCSS_W:0]      wsum;
  logic [ncdb_pkg::SCAT_W:0]      ssum;
  logic [ncdb_pkg::AVG_W:0]       avg_pair;
  logic [ncdb_pkg::NUM_W-1:0]     total_nxt;
  logic [KW-1:0]                  i_inc;
  logic [KW-1:0]                  j_inc;

  ncdb_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (sq_go_r),
    .radicand (sq_rad_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  ncdb_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (dv_go_r),
    .num   (dv_num_r),
    .den   (dv_den_r),
    .done  (dv_done),
    .quot  (dv_quot)
  );

  always_comb begin
    if ({2'b00, cfg.cluster_count} < 7'(MAX_CLUSTERS)) begin
      k = KW'(cfg.cluster_count);
    end else begin
      k = KW'(MAX_CLUSTERS);
    end
  end

  assign item_pop  = (state_r == S_IDLE) && item_valid && !res_valid_r;
  assign slot_ok   = ({3'b000, item.cluster_index} < 7'(MAX_CLUSTERS));
  assign mem_we    = item_pop && (item.mode == ncdb_pkg::MODE_LOAD) && slot_ok;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  assign opa      = (state_r == S_PT_ACC) ? p_r[{dim_r, 4'b0000} +: FW]
                                          : ci_r[{dim_r, 4'b0000} +: FW];
  assign opb      = cent_q_r[{dim_r, 4'b0000} +: FW];
  assign diff     = {opa[FW-1], opa} - {opb[FW-1], opb};
  assign mag      = diff[FW] ? (~diff + 1'b1) : diff;
  assign sq       = mag[FW-1:0] * mag[FW-1:0];
  assign acc_nxt  = acc_r + ncdb_pkg::DSQ_W'(sq);
  assign dim_last = (dim_r == 2'(DIMS - 1));

  assign pt_better = (j_r == '0) || (acc_r < best_r);
  assign best_nxt  = pt_better ? acc_r : best_r;
  assign bestj_nxt = pt_better ? j_r[AW-1:0] : bestj_r;

  assign wsum      = {1'b0, wcss_r} + (ncdb_pkg::WCSS_W + 1)'(best_r);
  assign ssum      = {1'b0, scat_r[bestj_r]} + (ncdb_pkg::SCAT_W + 1)'(sq_root);
  assign avg_pair  = {1'b0, avg_r[i_r[AW-1:0]]} + {1'b0, avg_r[j_r[AW-1:0]]};
  assign total_nxt = total_r + worst_r;
  assign i_inc     = i_r + 1'b1;
  assign j_inc     = j_r + 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cent_mem[AW'(item.cluster_index)] <= {item.feature_c, item.feature_b, item.feature_a};
    end
    cent_q_r <= cent_mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
      sq_go_r     <= 1'b0;
      dv_go_r     <= 1'b0;
      wcss_r      <= '0;
      seen_r      <= '0;
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
        scat_r[c] <= '0;
        cnt_r[c]  <= '0;
      end
    end else begin
      sq_go_r <= 1'b0;
      dv_go_r <= 1'b0;
      if (res_take) begin
        res_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (item_pop) begin
            res_r <= '0;
            unique case (item.mode)
              ncdb_pkg::MODE_LOAD: begin
                res_r.status <= slot_ok ? ncdb_pkg::ST_LOADED : ncdb_pkg::ST_BAD_SLOT;
                res_valid_r  <= 1'b1;
              end
              ncdb_pkg::MODE_POINT: begin
                if (k == '0) begin
                  res_r.status <= ncdb_pkg::ST_EMPTY;
                  res_valid_r  <= 1'b1;
                end else begin
                  p_r       <= {item.feature_c, item.feature_b, item.feature_a};
                  j_r       <= '0;
                  rd_addr_r <= '0;
                  dim_r     <= '0;
                  acc_r     <= '0;
                  state_r   <= S_PT_WAIT;
                end
              end
              ncdb_pkg::MODE_FINISH: begin
                if (k == '0) begin
                  res_r.status <= ncdb_pkg::ST_EMPTY;
                  res_valid_r  <= 1'b1;
                  wcss_r       <= '0;
                  seen_r       <= '0;
                  for (int c = 0; c < MAX_CLUSTERS; c++) begin
                    scat_r[c] <= '0;
                    cnt_r[c]  <= '0;
                  end
                end else begin
                  i_r     <= '0;
                  total_r <= '0;
                  state_r <= S_AVG_GO;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_PT_WAIT: state_r <= S_PT_ACC;
        S_PT_ACC: begin
          acc_r <= acc_nxt;
          dim_r <= dim_r + 2'd1;
          if (dim_last) begin
            state_r <= S_PT_CMP;
          end
        end
        S_PT_CMP: begin
          best_r  <= best_nxt;
          bestj_r <= bestj_nxt;
          if (j_inc == k) begin
            state_r <= S_PT_FIN;
          end else begin
            j_r       <= j_inc;
            rd_addr_r <= j_inc[AW-1:0];
            dim_r     <= '0;
            acc_r     <= '0;
            state_r   <= S_PT_WAIT;
          end
        end
        S_PT_FIN: begin
          if (seen_r < PW'(MAX_POINTS)) begin
            sq_go_r  <= 1'b1;
            sq_rad_r <= ncdb_pkg::RAD_W'(best_r);
            state_r  <= S_PT_ROOT;
          end else begin
            res_r.status      <= ncdb_pkg::ST_ASSIGNED;
            res_r.label       <= 4'(bestj_r);
            res_r.distance_sq <= best_r;
            res_valid_r       <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        S_PT_ROOT: begin
          if (sq_done) begin
            seen_r          <= seen_r + 1'b1;
            wcss_r          <= wsum[ncdb_pkg::WCSS_W] ? '1 : wsum[ncdb_pkg::WCSS_W-1:0];
            scat_r[bestj_r] <= ssum[ncdb_pkg::SCAT_W] ? '1 : ssum[ncdb_pkg::SCAT_W-1:0];
            if (cnt_r[bestj_r] < PW'(MAX_POINTS)) begin
              cnt_r[bestj_r] <= cnt_r[bestj_r] + 1'b1;
            end
            res_r.status      <= ncdb_pkg::ST_ASSIGNED;
            res_r.label       <= 4'(bestj_r);
            res_r.distance_sq <= best_r;
            res_valid_r       <= 1'b1;
            state_r           <= S_IDLE;
          end
        end
        S_AVG_GO: begin
          if (cnt_r[i_r[AW-1:0]] == '0) begin
            avg_r[i_r[AW-1:0]] <= '0;
            if (i_inc == k) begin
              i_r       <= '0;
              rd_addr_r <= '0;
              state_r   <= S_PI_WAIT;
            end else begin
              i_r <= i_inc;
            end
          end else begin
            dv_go_r  <= 1'b1;
            dv_num_r <= ncdb_pkg::NUM_W'({scat_r[i_r[AW-1:0]], 8'h00});
            dv_den_r <= ncdb_pkg::DEN_W'(cnt_r[i_r[AW-1:0]]);
            state_r  <= S_AVG_WAIT;
          end
        end
        S_AVG_WAIT: begin
          if (dv_done) begin
            avg_r[i_r[AW-1:0]] <= dv_quot[ncdb_pkg::AVG_W-1:0];
            if (i_inc == k) begin
              i_r       <= '0;
              rd_addr_r <= '0;
              state_r   <= S_PI_WAIT;
            end else begin
              i_r     <= i_inc;
              state_r <= S_AVG_GO;
            end
          end
        end
        S_PI_WAIT: state_r <= S_PI_LOAD;
        S_PI_LOAD: begin
          ci_r    <= cent_q_r;
          worst_r <= '0;
          j_r     <= '0;
          state_r <= S_PJ_NEXT;
        end
        S_PJ_NEXT: begin
          if (j_r == k) begin
            total_r <= total_nxt;
            if (i_inc == k) begin
              dv_go_r  <= 1'b1;
              dv_num_r <= total_nxt;
              dv_den_r <= ncdb_pkg::DEN_W'(k);
              state_r  <= S_DB_DIV;
            end else begin
              i_r       <= i_inc;
              rd_addr_r <= i_inc[AW-1:0];
              state_r   <= S_PI_WAIT;
            end
          end else if (j_r == i_r) begin
            j_r <= j_inc;
          end else begin
            rd_addr_r <= j_r[AW-1:0];
            dim_r     <= '0;
            acc_r     <= '0;
            state_r   <= S_PJ_WAIT;
          end
        end
        S_PJ_WAIT: state_r <= S_PJ_ACC;
        S_PJ_ACC: begin
          acc_r <= acc_nxt;
          dim_r <= dim_r + 2'd1;
          if (dim_last) begin
            sq_go_r  <= 1'b1;
            sq_rad_r <= {acc_nxt, 16'h0000};
            state_r  <= S_PJ_ROOT;
          end
        end
        S_PJ_ROOT: begin
          if (sq_done) begin
            if (sq_root > {1'b0, cfg.separation_floor, 8'h00}) begin
              dv_go_r  <= 1'b1;
              dv_num_r <= {avg_pair[ncdb_pkg::AVG_W-1:0], 16'h0000};
              dv_den_r <= sq_root;
              state_r  <= S_PJ_DIV;
            end else begin
              j_r     <= j_inc;
              state_r <= S_PJ_NEXT;
            end
          end
        end
        S_PJ_DIV: begin
          if (dv_done) begin
            if (dv_quot > worst_r) begin
              worst_r <= dv_quot;
            end
            j_r     <= j_inc;
            state_r <= S_PJ_NEXT;
          end
        end
        S_DB_DIV: begin
          if (dv_done) begin
            res_r.status <= ncdb_pkg::ST_METRICS;
            res_r.wcss   <= wcss_r;
            res_r.davies_bouldin <= (dv_quot[ncdb_pkg::NUM_W-1:ncdb_pkg::DB_W] != '0)
                                    ? '1 : dv_quot[ncdb_pkg::DB_W-1:0];
            res_valid_r  <= 1'b1;
            wcss_r       <= '0;
            seen_r       <= '0;
            for (int c = 0; c < MAX_CLUSTERS; c++) begin
              scat_r[c] <= '0;
              cnt_r[c]  <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/nearest_centroid_davies_bouldin_top.sv -----
`timescale 1ns / 1ps

// Nearest-centroid classifier with WCSS and Davies-Bouldin metrics. Items enter
// a two-deep queue and are carried out one at a time by a sequencer. A load
// item writes one centroid slot if its index is in range. A point item reads
// each active centroid from memory and adds one dimension of distance per cycle,
// then takes a square root that yields one bit per cycle. A finish item divides
// each non-empty cluster's scatter by its point count, then for each ordered
// centroid pair takes the distance, a one-bit-per-cycle square root and, above
// the separation floor, a 64-step division. Up to two further items are taken while one is at work.
module nearest_centroid_davies_bouldin_top #(
  parameter int MAX_CLUSTERS = 16,
  parameter int DIMS         = 3,
  parameter int MAX_POINTS   = 1048576
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,   // cluster_index, feature_a, feature_b, feature_c
  input  logic [1:0]   in_tuser,   // mode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // label, distance_sq, wcss, davies_bouldin
  output logic [2:0]   out_tuser,  // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [0:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  ncdb_pkg::cfg_t  cfg_r;
  ncdb_pkg::item_t in_item;
  ncdb_pkg::item_t item;
  ncdb_pkg::res_t  res;
  logic            item_valid;
  logic            item_pop;
  logic            res_valid;
  logic [6:0]      k_chk;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cluster_count    <= '0;
      cfg_r.separation_floor <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ncdb_pkg::REG_CLUSTER_COUNT:    cfg_r.cluster_count    <= cfg_data[4:0];
        ncdb_pkg::REG_SEPARATION_FLOOR: cfg_r.separation_floor <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign in_item.mode          = ncdb_pkg::mode_t'(in_tuser);
  assign in_item.cluster_index = in_tdata[3:0];
  assign in_item.feature_a     = in_tdata[19:4];
  assign in_item.feature_b     = in_tdata[35:20];
  assign in_item.feature_c     = in_tdata[51:36];

  ncdb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  ncdb_back #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .DIMS         (DIMS),
    .MAX_POINTS   (MAX_POINTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (out_tready)
  );

  assign out_tvalid = res_valid;
  assign out_tuser  = res.status;
  assign out_tdata  = {3'b000, res.davies_bouldin, res.wcss, res.distance_sq, res.label};

  assign k_chk = ({2'b00, cfg_r.cluster_count} < 7'(MAX_CLUSTERS))
                 ? {2'b00, cfg_r.cluster_count} : 7'(MAX_CLUSTERS);

  a_status_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ncdb_pkg::ST_LOADED || out_tuser == ncdb_pkg::ST_ASSIGNED ||
                    out_tuser == ncdb_pkg::ST_METRICS || out_tuser == ncdb_pkg::ST_EMPTY ||
                    out_tuser == ncdb_pkg::ST_BAD_SLOT))
    else $error("unknown result status");

  a_label_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ncdb_pkg::ST_ASSIGNED && k_chk <= 7'd16)
      |-> ({3'b000, res.label} < k_chk))
    else $error("label beyond active clusters");

  a_non_point_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ncdb_pkg::ST_ASSIGNED)
      |-> (res.label == '0 && res.distance_sq == '0))
    else $error("label or distance set on a non-point result");

endmodule
